/* src/gasp_pkg.sv */
// Shared types, constants and codes for the grid A* path search block.
package gasp_pkg;

  localparam int GRID_W      = 256;
  localparam int GRID_H      = 256;
  localparam int OPEN_DEPTH  = 1024;
  localparam int CELLS       = GRID_W * GRID_H;
  localparam int IDX_W       = $clog2(CELLS);
  localparam int OPEN_W      = $clog2(OPEN_DEPTH);
  localparam int CNT_W       = OPEN_W + 1;
  localparam int COST_W      = 20;
  localparam int LEN_W       = 17;
  localparam int XW          = 8;
  localparam logic [COST_W-1:0] STEP_COST = COST_W'(10);

  localparam logic [1:0] CMD_WRITE  = 2'd0;
  localparam logic [1:0] CMD_SEARCH = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_PATH  = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  localparam logic [1:0] CS_UNVISITED = 2'd0;
  localparam logic [1:0] CS_OPEN      = 2'd1;
  localparam logic [1:0] CS_CLOSED    = 2'd2;

  typedef struct packed {
    logic [1:0]    command;
    logic [XW-1:0] cell_x;
    logic [XW-1:0] cell_y;
    logic          blocked;
    logic [XW-1:0] goal_x;
    logic [XW-1:0] goal_y;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [XW-1:0]    path_x;
    logic [XW-1:0]    path_y;
    logic [LEN_W-1:0] path_length;
    logic             last;
  } out_item_t;

endpackage

/* src/gasp_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
module gasp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/grid_astar_path_search_top.sv */
// Top level of the grid A* path search block.
// Four-connected A* search over a 256x256 obstacle grid held in RAM. Each item is one
// command. A path read reports empty when no path is held. A search first clears the
// cell-status RAM in a sweep over all 65536 cells, then seeds the start cell. Each
// expansion then checks the goal and scans the open list through one shared compare
// unit. It compacts the list and tries four neighbours, skipping those off grid.
// The block takes no item while one is at work. After reset it first sweeps the
// obstacle map clear. Results wait in an output register.
module grid_astar_path_search_top
  import gasp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam logic [4:0] S_INIT   = 5'd0;
  localparam logic [4:0] S_IDLE   = 5'd1;
  localparam logic [4:0] S_CLEAR  = 5'd2;
  localparam logic [4:0] S_CHECK  = 5'd3;
  localparam logic [4:0] S_SC_A   = 5'd4;
  localparam logic [4:0] S_SC_B   = 5'd5;
  localparam logic [4:0] S_SC_C   = 5'd6;
  localparam logic [4:0] S_RM_A   = 5'd7;
  localparam logic [4:0] S_RM_B   = 5'd8;
  localparam logic [4:0] S_CUR    = 5'd9;
  localparam logic [4:0] S_NB     = 5'd10;
  localparam logic [4:0] S_NB_A   = 5'd11;
  localparam logic [4:0] S_NB_B   = 5'd12;
  localparam logic [4:0] S_WALK   = 5'd13;
  localparam logic [4:0] S_WALK_B = 5'd14;
  localparam logic [4:0] S_RD_A   = 5'd15;
  localparam logic [4:0] S_RD_B   = 5'd16;
  localparam logic [4:0] S_DONE   = 5'd17;
  localparam logic [4:0] S_GOAL_A = 5'd18;
  localparam logic [4:0] S_GOAL_B = 5'd19;

  logic [4:0]        state_r, state_nxt;
  in_item_t          cmd_r, cmd_nxt;
  logic [IDX_W:0]    sweep_r, sweep_nxt;
  logic [IDX_W-1:0]  s_r, s_nxt, g_r, g_nxt, cur_r, cur_nxt, nb_r, nb_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt, i_r, i_nxt, best_r, best_nxt;
  logic [COST_W-1:0] bf_r, bf_nxt, curg_r, curg_nxt;
  logic [2:0]        dir_r, dir_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [IDX_W-1:0]  pc_r, pc_nxt, hs_r, hs_nxt;
  logic              ready_r, ready_nxt;
  logic              ov_r, ov_nxt;
  out_item_t         od_r, od_nxt;

  logic              ob_we, ob_wd, ob_rd;
  logic [IDX_W-1:0]  ob_wa, ob_ra;
  logic              cs_we;
  logic [1:0]        cs_wd, cs_rd;
  logic [IDX_W-1:0]  cs_wa, cs_ra;
  logic              cc_we;
  logic [COST_W-1:0] cc_wd, cc_rd;
  logic [IDX_W-1:0]  cc_wa, cc_ra;
  logic              pd_we;
  logic [1:0]        pd_wd, pd_rd;
  logic [IDX_W-1:0]  pd_wa, pd_ra;
  logic              ol_we;
  logic [IDX_W-1:0]  ol_wd, ol_rd;
  logic [OPEN_W-1:0] ol_wa, ol_ra;

  gasp_ram #(.WIDTH(1), .DEPTH(CELLS)) u_obst (.clk(clk), .we(ob_we), .waddr(ob_wa),
    .wdata(ob_wd), .raddr(ob_ra), .rdata(ob_rd));
  gasp_ram #(.WIDTH(2), .DEPTH(CELLS)) u_stat (.clk(clk), .we(cs_we), .waddr(cs_wa),
    .wdata(cs_wd), .raddr(cs_ra), .rdata(cs_rd));
  gasp_ram #(.WIDTH(COST_W), .DEPTH(CELLS)) u_cost (.clk(clk), .we(cc_we), .waddr(cc_wa),
    .wdata(cc_wd), .raddr(cc_ra), .rdata(cc_rd));
  gasp_ram #(.WIDTH(2), .DEPTH(CELLS)) u_par (.clk(clk), .we(pd_we), .waddr(pd_wa),
    .wdata(pd_wd), .raddr(pd_ra), .rdata(pd_rd));
  gasp_ram #(.WIDTH(IDX_W), .DEPTH(OPEN_DEPTH)) u_open (.clk(clk), .we(ol_we),
    .waddr(ol_wa), .wdata(ol_wd), .raddr(ol_ra), .rdata(ol_rd));

  function automatic logic [COST_W-1:0] heur(input logic [IDX_W-1:0] idx,
                                             input logic [XW-1:0] gx,
                                             input logic [XW-1:0] gy);
    logic [XW-1:0] x, y, dx, dy;
    begin
      x  = idx[XW-1:0];
      y  = idx[IDX_W-1:XW];
      dx = (x > gx) ? x - gx : gx - x;
      dy = (y > gy) ? y - gy : gy - y;
      heur = COST_W'(dx) + COST_W'(dy);
    end
  endfunction

  // neighbour in direction d of cell c; valid flag clear when off grid
  logic [XW-1:0]    cx, cy, nx, ny;
  logic             nb_ok;
  logic [IDX_W-1:0] nb_idx;
  always_comb begin
    cx = cur_r[XW-1:0];
    cy = cur_r[IDX_W-1:XW];
    nx = cx;
    ny = cy;
    nb_ok = 1'b1;
    case (dir_r[1:0])
      2'd0: begin
        nb_ok = (cx != XW'(GRID_W - 1));
        nx = cx + 1'b1;
      end
      2'd1: begin
        nb_ok = (cx != '0);
        nx = cx - 1'b1;
      end
      2'd2: begin
        nb_ok = (cy != XW'(GRID_H - 1));
        ny = cy + 1'b1;
      end
      default: begin
        nb_ok = (cy != '0);
        ny = cy - 1'b1;
      end
    endcase
    nb_idx = {ny, nx};
  end

  // parent step of pc_r given pd_rd
  logic [XW-1:0]    px, py, qx, qy;
  logic             par_ok;
  logic [IDX_W-1:0] par_idx;
  always_comb begin
    px = pc_r[XW-1:0];
    py = pc_r[IDX_W-1:XW];
    qx = px;
    qy = py;
    par_ok = 1'b1;
    case (pd_rd)
      2'd0: begin
        par_ok = (px != '0);
        qx = px - 1'b1;
      end
      2'd1: begin
        par_ok = (px != XW'(GRID_W - 1));
        qx = px + 1'b1;
      end
      2'd2: begin
        par_ok = (py != '0);
        qy = py - 1'b1;
      end
      default: begin
        par_ok = (py != XW'(GRID_H - 1));
        qy = py + 1'b1;
      end
    endcase
    par_idx = {qy, qx};
  end

  logic [COST_W-1:0] f_cand, ng;
  assign f_cand = cc_rd + heur(ol_rd, cmd_r.goal_x, cmd_r.goal_y);
  assign ng     = curg_r + STEP_COST;

  assign in_stall  = (state_r != S_IDLE) || out_valid;
  assign out_valid = (state_r == S_DONE);
  assign out_data  = od_r;

  always_comb begin
    state_nxt = state_r;
    cmd_nxt = cmd_r;
    sweep_nxt = sweep_r;
    s_nxt = s_r;
    g_nxt = g_r;
    cur_nxt = cur_r;
    nb_nxt = nb_r;
    cnt_nxt = cnt_r;
    i_nxt = i_r;
    best_nxt = best_r;
    bf_nxt = bf_r;
    curg_nxt = curg_r;
    dir_nxt = dir_r;
    len_nxt = len_r;
    pc_nxt = pc_r;
    hs_nxt = hs_r;
    ready_nxt = ready_r;
    ov_nxt = ov_r;
    od_nxt = od_r;
    ob_we = 1'b0; ob_wa = sweep_r[IDX_W-1:0]; ob_wd = 1'b0; ob_ra = nb_r;
    cs_we = 1'b0; cs_wa = sweep_r[IDX_W-1:0]; cs_wd = CS_UNVISITED; cs_ra = nb_r;
    cc_we = 1'b0; cc_wa = nb_r; cc_wd = ng; cc_ra = ol_rd;
    pd_we = 1'b0; pd_wa = nb_r; pd_wd = dir_r[1:0]; pd_ra = pc_r;
    ol_we = 1'b0; ol_wa = cnt_r[OPEN_W-1:0]; ol_wd = nb_r; ol_ra = i_r[OPEN_W-1:0];
    unique case (state_r)
      S_INIT: begin
        ob_we = 1'b1;
        sweep_nxt = sweep_r + 1'b1;
        if (sweep_r == (IDX_W+1)'(CELLS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          cmd_nxt = in_data;
          od_nxt = '0;
          unique case (in_data.command)
            CMD_WRITE: begin
              ob_we = 1'b1;
              ob_wa = {in_data.cell_y, in_data.cell_x};
              ob_wd = in_data.blocked;
              state_nxt = S_DONE;
            end
            CMD_SEARCH: begin
              sweep_nxt = '0;
              ready_nxt = 1'b0;
              s_nxt = {in_data.cell_y, in_data.cell_x};
              g_nxt = {in_data.goal_y, in_data.goal_x};
              state_nxt = S_CLEAR;
            end
            CMD_READ: begin
              if (!ready_r) begin
                od_nxt.status = ST_EMPTY;
                state_nxt = S_DONE;
              end else begin
                state_nxt = S_RD_A;
              end
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_CLEAR: begin
        if (sweep_r == (IDX_W+1)'(CELLS)) begin
          cs_we = 1'b1;
          cs_wa = s_r;
          cs_wd = CS_OPEN;
          cc_we = 1'b1;
          cc_wa = s_r;
          cc_wd = '0;
          pd_we = 1'b1;
          pd_wa = s_r;
          pd_wd = 2'd0;
          ol_we = 1'b1;
          ol_wa = '0;
          ol_wd = s_r;
          cnt_nxt = CNT_W'(1);
          ov_nxt = 1'b0;
          state_nxt = S_GOAL_A;
        end else begin
          cs_we = 1'b1;
          sweep_nxt = sweep_r + 1'b1;
        end
      end
      S_GOAL_A: begin
        cs_ra = g_r;
        state_nxt = S_GOAL_B;
      end
      S_GOAL_B: begin
        if (ov_r) begin
          od_nxt.status = ST_OVERFLOW;
          state_nxt = S_DONE;
        end else if (cs_rd == CS_OPEN) begin
          pc_nxt = g_r;
          len_nxt = LEN_W'(1);
          state_nxt = S_WALK;
        end else if (cnt_r == '0) begin
          od_nxt.status = ST_NO_PATH;
          state_nxt = S_DONE;
        end else begin
          i_nxt = '0;
          best_nxt = '0;
          state_nxt = S_SC_A;
        end
      end
      S_SC_A: begin
        ol_ra = i_r[OPEN_W-1:0];
        state_nxt = S_SC_B;
      end
      S_SC_B: begin
        cc_ra = ol_rd;
        state_nxt = S_SC_C;
      end
      S_SC_C: begin
        if (i_r == '0 || f_cand < bf_r) begin
          bf_nxt = f_cand;
          best_nxt = i_r;
          cur_nxt = ol_rd;
          curg_nxt = cc_rd;
        end
        i_nxt = i_r + 1'b1;
        if (i_r + 1'b1 == cnt_r) begin
          i_nxt = (i_r == '0 || f_cand < bf_r) ? i_r : best_r;
          state_nxt = S_RM_A;
        end else begin
          state_nxt = S_SC_A;
        end
      end
      S_RM_A: begin
        if (i_r + 1'b1 >= cnt_r) begin
          cnt_nxt = cnt_r - 1'b1;
          cs_we = 1'b1;
          cs_wa = cur_r;
          cs_wd = CS_CLOSED;
          dir_nxt = '0;
          state_nxt = S_NB;
        end else begin
          ol_ra = OPEN_W'(i_r + 1'b1);
          state_nxt = S_RM_B;
        end
      end
      S_RM_B: begin
        ol_we = 1'b1;
        ol_wa = i_r[OPEN_W-1:0];
        ol_wd = ol_rd;
        i_nxt = i_r + 1'b1;
        state_nxt = S_RM_A;
      end
      S_NB: begin
        if (dir_r[2]) begin
          state_nxt = S_GOAL_A;
        end else if (!nb_ok) begin
          dir_nxt = dir_r + 1'b1;
        end else begin
          nb_nxt = nb_idx;
          state_nxt = S_NB_A;
        end
      end
      S_NB_A: begin
        ob_ra = nb_r;
        cs_ra = nb_r;
        cc_ra = nb_r;
        state_nxt = S_NB_B;
      end
      S_NB_B: begin
        dir_nxt = dir_r + 1'b1;
        state_nxt = S_NB;
        if (!ob_rd && cs_rd != CS_CLOSED) begin
          if (cs_rd == CS_OPEN) begin
            if (cc_rd > ng) begin
              cc_we = 1'b1;
              pd_we = 1'b1;
            end
          end else if (cnt_r >= CNT_W'(OPEN_DEPTH)) begin
            ov_nxt = 1'b1;
            state_nxt = S_GOAL_B;
          end else begin
            cc_we = 1'b1;
            pd_we = 1'b1;
            cs_we = 1'b1;
            cs_wa = nb_r;
            cs_wd = CS_OPEN;
            ol_we = 1'b1;
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      S_WALK: begin
        if (pc_r == s_r) begin
          od_nxt.path_length = len_r;
          hs_nxt = s_r;
          pc_nxt = g_r;
          ready_nxt = 1'b1;
          state_nxt = S_DONE;
        end else begin
          pd_ra = pc_r;
          state_nxt = S_WALK_B;
        end
      end
      S_WALK_B: begin
        if (!par_ok) begin
          pc_nxt = s_r;
        end else begin
          pc_nxt = par_idx;
          len_nxt = len_r + 1'b1;
        end
        if (!par_ok) begin
          od_nxt.path_length = len_r;
          hs_nxt = s_r;
          pc_nxt = g_r;
          ready_nxt = 1'b1;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_WALK;
        end
      end
      S_RD_A: begin
        pd_ra = pc_r;
        state_nxt = S_RD_B;
      end
      S_RD_B: begin
        od_nxt.path_x = pc_r[XW-1:0];
        od_nxt.path_y = pc_r[IDX_W-1:XW];
        od_nxt.path_length = len_r;
        if (pc_r == hs_r || !par_ok) begin
          od_nxt.last = (pc_r == hs_r);
          ready_nxt = 1'b0;
        end else begin
          pc_nxt = par_idx;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      sweep_r <= '0;
      ready_r <= 1'b0;
      len_r   <= '0;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sweep_r <= sweep_nxt;
      ready_r <= ready_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    s_r    <= s_nxt;
    g_r    <= g_nxt;
    cur_r  <= cur_nxt;
    nb_r   <= nb_nxt;
    i_r    <= i_nxt;
    best_r <= best_nxt;
    bf_r   <= bf_nxt;
    curg_r <= curg_nxt;
    dir_r  <= dir_nxt;
    pc_r   <= pc_nxt;
    hs_r   <= hs_nxt;
    od_r   <= od_nxt;
  end

endmodule

/* bench/gasp_checker.sv */
`timescale 1ns / 100ps
// Scoreboard for the grid A* search block: predicts every result and compares it.
module gasp_checker
  import gasp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_data,
  output int        mismatches,
  output int        pending
);

  bit               obst [CELLS];
  logic [1:0]       cstat [CELLS];
  int unsigned      gcost [CELLS];
  logic [1:0]       pdir [CELLS];
  int unsigned      open_cells [$];
  bit               path_held;
  int unsigned      path_cursor;
  int unsigned      held_len;
  int unsigned      held_start;
  out_item_t        expected_q [$];

  function automatic int unsigned manhattan(int unsigned idx, int unsigned gx,
                                            int unsigned gy);
    int unsigned x, y;
    x = idx % GRID_W;
    y = idx / GRID_W;
    return (x > gx ? x - gx : gx - x) + (y > gy ? y - gy : gy - y);
  endfunction

  function bit step_back(int unsigned idx, output int unsigned par);
    int unsigned x, y;
    bit ok;
    x = idx % GRID_W;
    y = idx / GRID_W;
    ok = 1;
    par = idx;
    case (pdir[idx])
      2'd0: if (x == 0) ok = 0; else x--;
      2'd1: if (x + 1 >= GRID_W) ok = 0; else x++;
      2'd2: if (y == 0) ok = 0; else y--;
      default: if (y + 1 >= GRID_H) ok = 0; else y++;
    endcase
    if (ok) par = y * GRID_W + x;
    return ok;
  endfunction

  function logic [1:0] astar_search(int unsigned sx, int unsigned sy, int unsigned gx,
                                    int unsigned gy);
    int unsigned s, g, best, bf, f, cur, cx, cy, nx, ny, n, ng, cnt, guard, par;
    bit ok;
    for (int i = 0; i < CELLS; i++) cstat[i] = CS_UNVISITED;
    open_cells.delete();
    path_held = 0;
    held_len = 0;
    if (sx >= GRID_W || sy >= GRID_H || gx >= GRID_W || gy >= GRID_H) return ST_NO_PATH;
    s = sy * GRID_W + sx;
    g = gy * GRID_W + gx;
    gcost[s] = 0;
    pdir[s] = 2'd0;
    cstat[s] = CS_OPEN;
    open_cells = {open_cells, s};
    while (cstat[g] != CS_OPEN) begin
      if (open_cells.size() == 0) return ST_NO_PATH;
      best = 0;
      bf = gcost[open_cells[0]] + manhattan(open_cells[0], gx, gy);
      for (int i = 1; i < open_cells.size(); i++) begin
        f = gcost[open_cells[i]] + manhattan(open_cells[i], gx, gy);
        if (f < bf) begin
          bf = f;
          best = i;
        end
      end
      cur = open_cells[best];
      open_cells.delete(best);
      cstat[cur] = CS_CLOSED;
      cx = cur % GRID_W;
      cy = cur / GRID_W;
      for (int d = 0; d < 4; d++) begin
        ok = 1;
        nx = cx;
        ny = cy;
        case (d)
          0: if (cx + 1 >= GRID_W) ok = 0; else nx = cx + 1;
          1: if (cx == 0) ok = 0; else nx = cx - 1;
          2: if (cy + 1 >= GRID_H) ok = 0; else ny = cy + 1;
          default: if (cy == 0) ok = 0; else ny = cy - 1;
        endcase
        n = ny * GRID_W + nx;
        if (ok && !obst[n] && cstat[n] != CS_CLOSED) begin
          ng = gcost[cur] + STEP_COST;
          if (cstat[n] == CS_OPEN) begin
            if (gcost[n] > ng) begin
              gcost[n] = ng;
              pdir[n] = d[1:0];
            end
          end else begin
            if (open_cells.size() >= OPEN_DEPTH) return ST_OVERFLOW;
            gcost[n] = ng;
            pdir[n] = d[1:0];
            cstat[n] = CS_OPEN;
            open_cells = {open_cells, n};
          end
        end
      end
    end
    cur = g;
    cnt = 1;
    for (guard = 0; cur != s && guard < CELLS; guard++) begin
      if (!step_back(cur, par)) break;
      cur = par;
      cnt++;
    end
    held_len = cnt;
    held_start = s;
    path_cursor = g;
    path_held = 1;
    return ST_OK;
  endfunction

  function out_item_t apply_command(in_item_t it);
    out_item_t r;
    int unsigned cur, par;
    r = '0;
    case (it.command)
      CMD_WRITE: obst[it.cell_y * GRID_W + it.cell_x] = it.blocked;
      CMD_SEARCH: begin
        r.status = astar_search(it.cell_x, it.cell_y, it.goal_x, it.goal_y);
        if (r.status == ST_OK) r.path_length = held_len[LEN_W-1:0];
      end
      CMD_READ: begin
        if (!path_held) begin
          r.status = ST_EMPTY;
        end else begin
          cur = path_cursor % CELLS;
          r.path_x = XW'(cur % GRID_W);
          r.path_y = XW'(cur / GRID_W);
          r.path_length = held_len[LEN_W-1:0];
          if (cur == held_start) begin
            r.last = 1'b1;
            path_held = 0;
          end else if (!step_back(cur, par)) begin
            path_held = 0;
          end else begin
            path_cursor = par;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    out_item_t want, pred;
    if (!rst_n) begin
      mismatches = 0;
      pending = 0;
      path_held = 0;
      path_cursor = 0;
      held_len = 0;
      held_start = 0;
      expected_q.delete();
      open_cells.delete();
      for (int i = 0; i < CELLS; i++) begin
        obst[i] = 0;
        cstat[i] = CS_UNVISITED;
      end
    end else begin
      if (in_valid && !in_stall) begin
        pred = apply_command(in_data);
        expected_q = {expected_q, pred};
      end
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] unexpected result status=%0d x=%0d y=%0d len=%0d last=%0d",
                     $realtime, out_data.status, out_data.path_x, out_data.path_y,
                     out_data.path_length, out_data.last);
        end else begin
          want = expected_q.pop_front();
          if (out_data.status !== want.status || out_data.path_x !== want.path_x ||
              out_data.path_y !== want.path_y || out_data.path_length !== want.path_length ||
              out_data.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("[%0t] mismatch exp st=%0d x=%0d y=%0d len=%0d last=%0d, ",
                       $realtime, want.status, want.path_x, want.path_y, want.path_length,
                       want.last, "got st=%0d x=%0d y=%0d len=%0d last=%0d",
                       out_data.status, out_data.path_x, out_data.path_y,
                       out_data.path_length, out_data.last);
          end
        end
      end
      pending = expected_q.size();
    end
  end

endmodule

/* bench/tb_grid_astar_path_search_top.sv */
`timescale 1ns / 100ps
// Testbench top for the grid A* search block: stimulus, flow control and verdict.
module tb_grid_astar_path_search_top;
  import gasp_pkg::*;

  localparam logic [1:0] CMD_NOP = 2'd3;
  localparam longint     CYCLE_LIMIT = 100_000_000;
  localparam int         RANDOM_ITEMS = 1600;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  int        mismatches;
  int        pending;
  longint    cycles = 0;
  int        burst_left;
  int        n_write, n_search, n_read, n_other;
  int        stall_mode = 0;

  grid_astar_path_search_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  gasp_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .mismatches(mismatches), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("grid_astar_path_search_top test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (cycles % 64 == 0) stall_mode = $urandom_range(0, 2);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 99) < 30);
      default: out_stall <= ($urandom_range(0, 99) < 75);
    endcase
  end

  function automatic in_item_t mk(logic [1:0] cmd, int x, int y, bit b, int gx, int gy);
    in_item_t it;
    it.command = cmd;
    it.cell_x = XW'(x);
    it.cell_y = XW'(y);
    it.blocked = b;
    it.goal_x = XW'(gx);
    it.goal_y = XW'(gy);
    return it;
  endfunction

  task automatic send(in_item_t it);
    int gap;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_data <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    case (it.command)
      CMD_WRITE: n_write++;
      CMD_SEARCH: n_search++;
      CMD_READ: n_read++;
      default: n_other++;
    endcase
  endtask

  task automatic write_cell(int x, int y, bit b);
    send(mk(CMD_WRITE, x, y, b, $urandom_range(0, 255), $urandom_range(0, 255)));
  endtask

  task automatic search(int sx, int sy, int gx, int gy);
    send(mk(CMD_SEARCH, sx, sy, 1'($urandom_range(0, 1)), gx, gy));
  endtask

  task automatic read_path(int count);
    repeat (count)
      send(mk(CMD_READ, $urandom_range(0, 255), $urandom_range(0, 255),
              1'($urandom_range(0, 1)), $urandom_range(0, 255), $urandom_range(0, 255)));
  endtask

  initial begin
    int r, x, y;
    rst_n = 0;
    in_valid = 0;
    in_data = '0;
    burst_left = 0;
    n_write = 0;
    n_search = 0;
    n_read = 0;
    n_other = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // wall off a 16x16 corner so every search there stays bounded
    for (int i = 0; i <= 16; i++) write_cell(16, i, 1);
    for (int i = 0; i < 16; i++) write_cell(i, 16, 1);

    read_path(1);
    write_cell(255, 255, 1);
    write_cell(255, 255, 0);
    search(255, 255, 255, 255);
    read_path(2);
    search(255, 0, 254, 0);
    read_path(3);
    send(mk(CMD_NOP, 255, 255, 1, 255, 255));
    write_cell(3, 3, 1);
    search(3, 3, 5, 3);
    read_path(4);
    write_cell(3, 3, 0);
    write_cell(2, 0, 1);
    write_cell(2, 1, 1);
    write_cell(0, 2, 1);
    write_cell(1, 2, 1);
    write_cell(1, 1, 1);
    search(0, 0, 1, 1);
    read_path(1);
    search(0, 0, 1, 0);
    write_cell(1, 1, 0);
    search(0, 0, 5, 5);
    read_path(2);
    write_cell(2, 0, 0);
    write_cell(2, 1, 0);
    write_cell(0, 2, 0);
    write_cell(1, 2, 0);
    search(0, 0, 15, 15);
    read_path(32);

    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      r = $urandom_range(0, 99);
      if (r < 2) begin
        search($urandom_range(0, 15), $urandom_range(0, 15),
               $urandom_range(0, 15), $urandom_range(0, 15));
      end else if (r < 3) begin
        send(mk(CMD_NOP, $urandom_range(0, 255), $urandom_range(0, 255),
                1'($urandom_range(0, 1)), $urandom_range(0, 255), $urandom_range(0, 255)));
      end else if (r < 40) begin
        read_path(1);
      end else if ($urandom_range(0, 3) != 0) begin
        write_cell($urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 99) < 30);
      end else begin
        if ($urandom_range(0, 1) == 0) begin
          x = $urandom_range(17, 255);
          y = $urandom_range(0, 255);
        end else begin
          x = $urandom_range(0, 255);
          y = $urandom_range(17, 255);
        end
        write_cell(x, y, 1'($urandom_range(0, 1)));
      end
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("Covered %0d obstacle writes, %0d searches, %0d path reads, %0d unused commands",
             n_write, n_search, n_read, n_other);
    $display("with bursty input, patterned output stalls and %0d cycles in all", cycles);
    if (mismatches == 0 && pending == 0) begin
      $display("grid_astar_path_search_top test passed");
    end else begin
      $display("grid_astar_path_search_top test failed");
    end
    $finish;
  end

endmodule
